FILE: hw/rtl/fnif_pkg.sv
`default_nettype none
package fnif_pkg;

    localparam int FNIF_MAX_WIDTH   = 1024;
    localparam int FNIF_WIDTH_W     = 11;
    localparam int FNIF_THR_W       = 8;
    localparam int FNIF_CFG_DATA_W  = 11;
    localparam int FNIF_CFG_INDEX_W = 1;
    localparam int FNIF_PIX_W       = 8;
    localparam int FNIF_QUEUE_DEPTH = 2;

    localparam logic [FNIF_CFG_INDEX_W-1:0] FNIF_REG_IMAGE_WIDTH    = 1'd0;
    localparam logic [FNIF_CFG_INDEX_W-1:0] FNIF_REG_DIFF_THRESHOLD = 1'd1;

    localparam logic [FNIF_WIDTH_W-1:0] FNIF_IMAGE_WIDTH_RESET    = 11'd1024;
    localparam logic [FNIF_THR_W-1:0]   FNIF_DIFF_THRESHOLD_RESET = 8'd1;

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_DRAIN = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [FNIF_PIX_W-1:0] pixel_in;
    } fnif_in_t;

    typedef struct packed {
        logic [FNIF_PIX_W-1:0] pixel_out;
        logic                  replaced;
        logic                  row_end;
        logic                  frame_end;
    } fnif_out_t;

    // one classified item handed from the front to the back
    typedef struct packed {
        logic                  is_emit;
        logic                  last;
        logic                  drain;
        logic                  upper;
        logic [FNIF_PIX_W-1:0] pix;
    } fnif_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fnif_q_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fnif_front.sv
`default_nettype none
module fnif_front #(
    parameter int MAX_WIDTH = fnif_pkg::FNIF_MAX_WIDTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire fnif_pkg::fnif_in_t                  s_data,
    input  wire logic [fnif_pkg::FNIF_WIDTH_W-1:0]   image_width,
    input  wire fnif_pkg::fnif_q_status_t            q_status,
    output logic                                     push,
    output fnif_pkg::fnif_cmd_t                      push_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]             push_col
);
    import fnif_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int LEN_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (LEN_W > FNIF_WIDTH_W) ? LEN_W : FNIF_WIDTH_W;

    logic [CNT_W-1:0] col_reg, col_next;
    logic             full_row_reg, full_row_next;
    logic             upper_reg, upper_next;
    logic             draining_reg, draining_next;

    logic             accept;
    logic             drain;
    logic             last;
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] eff_width;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] col_cl;
    logic [CNT_W-1:0] col_inc;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign drain   = (s_data.action == ACTION_DRAIN) || draining_reg;

    // zero acts as one, anything above the line buffer acts as its size
    always_comb begin
        width_ext = CMP_W'(image_width);
        if (width_ext == '0) begin
            eff_width = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
        col_ext = CMP_W'(col_reg);
        col_cl  = (col_ext >= eff_width) ? (eff_width - CMP_W'(1)) : col_ext;
        last    = ((col_cl + CMP_W'(1)) >= eff_width);
        col_inc = CNT_W'(col_cl + CMP_W'(1));
    end

    always_comb begin
        push_col         = col_cl[CNT_W-1:0];
        push_cmd.is_emit = full_row_reg;
        push_cmd.last    = last;
        push_cmd.drain   = drain;
        push_cmd.upper   = upper_reg;
        push_cmd.pix     = s_data.pixel_in;
        push             = accept && (full_row_reg || !drain);
    end

    always_comb begin
        col_next      = col_reg;
        full_row_next = full_row_reg;
        upper_next    = upper_reg;
        draining_next = draining_reg;
        if (accept) begin
            if (!full_row_reg) begin
                // first row is only stored, a drain here has nothing to flush
                if (!drain) begin
                    col_next = last ? '0 : col_inc;
                    if (last) begin
                        full_row_next = 1'b1;
                    end
                end
            end else if (drain) begin
                if (last) begin
                    col_next      = '0;
                    full_row_next = 1'b0;
                    upper_next    = 1'b0;
                    draining_next = 1'b0;
                end else begin
                    col_next      = col_inc;
                    draining_next = 1'b1;
                end
            end else begin
                col_next = last ? '0 : col_inc;
                if (last) begin
                    upper_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            full_row_reg <= 1'b0;
            upper_reg    <= 1'b0;
            draining_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            full_row_reg <= full_row_next;
            upper_reg    <= upper_next;
            draining_reg <= draining_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fnif_queue.sv
`default_nettype none
module fnif_queue #(
    parameter int COL_W = $clog2(fnif_pkg::FNIF_MAX_WIDTH)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     push,
    input  wire fnif_pkg::fnif_cmd_t      push_cmd,
    input  wire logic [COL_W-1:0]         push_col,
    input  wire logic                     pop,
    output fnif_pkg::fnif_cmd_t           head_cmd,
    output logic [COL_W-1:0]              head_col,
    output fnif_pkg::fnif_q_status_t      status
);
    import fnif_pkg::*;

    localparam int QD    = FNIF_QUEUE_DEPTH;
    localparam int PTR_W = $clog2(QD);
    localparam int CNT_W = $clog2(QD + 1);

    fnif_cmd_t        cmd_reg [QD];
    logic [COL_W-1:0] col_reg [QD];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(QD));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = cmd_reg[rd_ptr_reg];
    assign head_col     = col_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QD - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QD - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            cmd_reg[wr_ptr_reg] <= push_cmd;
            col_reg[wr_ptr_reg] <= push_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fnif_back.sv
`default_nettype none
module fnif_back #(
    parameter int MAX_WIDTH = fnif_pkg::FNIF_MAX_WIDTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire fnif_pkg::fnif_cmd_t                head_cmd,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]       head_col,
    input  wire fnif_pkg::fnif_q_status_t           q_status,
    output logic                                    pop,
    input  wire logic [fnif_pkg::FNIF_THR_W-1:0]    diff_threshold,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output fnif_pkg::fnif_out_t                     m_data
);
    import fnif_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;
    localparam logic [21:0] RECIP6       = 22'd683;
    localparam int          RECIP6_SHIFT = 12;

    logic [FNIF_PIX_W-1:0] orig_mem [MAX_WIDTH];
    logic [FNIF_PIX_W-1:0] filt_mem [MAX_WIDTH];

    logic                  state_reg, state_next;
    fnif_cmd_t             hold_cmd_reg;
    logic [CNT_W-1:0]      hold_col_reg;
    logic [FNIF_PIX_W-1:0] orig_c_reg, orig_r_reg, filt_c_reg;
    logic [FNIF_PIX_W-1:0] left_reg, left_next;
    logic                  m_valid_reg, m_valid_next;
    fnif_out_t             m_data_reg, m_data_next;

    logic                  rd_en;
    logic [CNT_W-1:0]      rd_addr_r;
    logic                  orig_we;
    logic [CNT_W-1:0]      orig_waddr;
    logic [FNIF_PIX_W-1:0] orig_wdata;
    logic                  filt_we;
    logic                  out_free;

    logic                  has_left, has_right, has_up, has_down;
    logic                  far_left, far_right, far_up, far_down;
    logic                  all_far, rep;
    logic [2:0]            n_cnt;
    logic [9:0]            sum;
    logic [10:0]           sum3x;
    logic [21:0]           prod6;
    logic [FNIF_PIX_W-1:0] mean;
    logic [FNIF_PIX_W-1:0] res;

    function automatic logic far_from(input logic [FNIF_PIX_W-1:0] p,
                                      input logic [FNIF_PIX_W-1:0] q,
                                      input logic [FNIF_THR_W-1:0] thr);
        logic [FNIF_PIX_W-1:0] d;
        d = (p > q) ? (p - q) : (q - p);
        return d > thr;
    endfunction

    assign rd_addr_r = head_col + CNT_W'(1);
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // neighbours: left and upper are filtered, right and lower are originals
    always_comb begin
        has_left  = (hold_col_reg != '0);
        has_right = !hold_cmd_reg.last;
        has_up    = hold_cmd_reg.upper;
        has_down  = !hold_cmd_reg.drain;
        far_left  = far_from(orig_c_reg, left_reg, diff_threshold);
        far_right = far_from(orig_c_reg, orig_r_reg, diff_threshold);
        far_up    = far_from(orig_c_reg, filt_c_reg, diff_threshold);
        far_down  = far_from(orig_c_reg, hold_cmd_reg.pix, diff_threshold);
        all_far   = (far_left || !has_left) && (far_right || !has_right) &&
                    (far_up || !has_up) && (far_down || !has_down);
        n_cnt     = 3'(has_left) + 3'(has_right) + 3'(has_up) + 3'(has_down);
        sum       = (has_left  ? 10'(left_reg)         : 10'd0) +
                    (has_right ? 10'(orig_r_reg)       : 10'd0) +
                    (has_up    ? 10'(filt_c_reg)       : 10'd0) +
                    (has_down  ? 10'(hold_cmd_reg.pix) : 10'd0);
        rep       = all_far && (n_cnt != 3'd0);
        // round(sum / 3) with halves up is (2 sum + 3) / 6, by reciprocal
        sum3x     = {sum, 1'b0} + 11'd3;
        prod6     = 22'(sum3x) * RECIP6;
        case (n_cnt)
            3'd1:    mean = sum[7:0];
            3'd2:    mean = 8'((11'(sum) + 11'd1) >> 1);
            3'd3:    mean = prod6[RECIP6_SHIFT +: FNIF_PIX_W];
            3'd4:    mean = 8'((11'(sum) + 11'd2) >> 2);
            default: mean = orig_c_reg;
        endcase
        res = rep ? mean : orig_c_reg;
    end

    always_comb begin
        state_next   = state_reg;
        pop          = 1'b0;
        rd_en        = 1'b0;
        orig_we      = 1'b0;
        orig_waddr   = head_col;
        orig_wdata   = head_cmd.pix;
        filt_we      = 1'b0;
        left_next    = left_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop = 1'b1;
                    if (head_cmd.is_emit) begin
                        rd_en      = 1'b1;
                        state_next = ST_CALC;
                    end else begin
                        orig_we = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                if (out_free) begin
                    filt_we               = 1'b1;
                    orig_we               = !hold_cmd_reg.drain;
                    orig_waddr            = hold_col_reg;
                    orig_wdata            = hold_cmd_reg.pix;
                    left_next             = res;
                    m_valid_next          = 1'b1;
                    m_data_next.pixel_out = res;
                    m_data_next.replaced  = rep;
                    m_data_next.row_end   = hold_cmd_reg.last;
                    m_data_next.frame_end = hold_cmd_reg.drain && hold_cmd_reg.last;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (orig_we) begin
            orig_mem[orig_waddr] <= orig_wdata;
        end
        if (rd_en) begin
            orig_c_reg <= orig_mem[head_col];
            orig_r_reg <= orig_mem[rd_addr_r];
        end
    end

    always_ff @(posedge aclk) begin
        if (filt_we) begin
            filt_mem[hold_col_reg] <= res;
        end
        if (rd_en) begin
            filt_c_reg <= filt_mem[head_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hold_cmd_reg <= head_cmd;
            hold_col_reg <= head_col;
        end
        left_reg   <= left_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/four_neighbour_impulse_filter.sv
`default_nettype none
// four-neighbour impulse filter for an 8-bit raster pixel stream
// s_* channel: one pixel (action = pixel) or drain tick (action = drain) per transfer
// m_* channel: filtered pixel with replaced, row_end and frame_end flags
// results run one row behind the input; after the last row, send one drain tick
// per pixel of a row to flush it, frame_end marks the last flushed pixel
// cfg_*: image_width (index 0) and diff_threshold (index 1), written while idle
// a first-row pixel is stored straight from the sequencer's idle state; every pixel
// that yields a result takes the line memory read followed by the compute/write step,
// which waits while the output holds an unaccepted result; the result of the pixel
// above passes the queue, the line memory read and the output register
// a two-entry queue separates the input classifier from the memory sequencer, so
// input keeps flowing while a result waits in the output register
// when the receiver stalls, the output register holds, the sequencer waits,
// then the queue fills and s_ready drops
// synchronous reset clears row position, row flags, queue and output valid;
// line memories are not cleared and are filled by the first row of a frame
module four_neighbour_impulse_filter #(
    parameter int MAX_WIDTH = fnif_pkg::FNIF_MAX_WIDTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire fnif_pkg::fnif_in_t                     s_data,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output fnif_pkg::fnif_out_t                         m_data,
    input  wire logic                                   cfg_write_en,
    input  wire logic [fnif_pkg::FNIF_CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [fnif_pkg::FNIF_CFG_DATA_W-1:0]   cfg_data
);
    import fnif_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH);

    logic [FNIF_WIDTH_W-1:0] image_width_reg, image_width_next;
    logic [FNIF_THR_W-1:0]   diff_threshold_reg, diff_threshold_next;

    logic             q_push;
    fnif_cmd_t        q_push_cmd;
    logic [CNT_W-1:0] q_push_col;
    logic             q_pop;
    fnif_cmd_t        q_head_cmd;
    logic [CNT_W-1:0] q_head_col;
    fnif_q_status_t   q_status;

    always_comb begin
        image_width_next    = image_width_reg;
        diff_threshold_next = diff_threshold_reg;
        if (cfg_write_en) begin
            case (cfg_index)
                FNIF_REG_IMAGE_WIDTH:    image_width_next    = cfg_data[FNIF_WIDTH_W-1:0];
                FNIF_REG_DIFF_THRESHOLD: diff_threshold_next = cfg_data[FNIF_THR_W-1:0];
                default: begin
                    image_width_next    = image_width_reg;
                    diff_threshold_next = diff_threshold_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg    <= FNIF_IMAGE_WIDTH_RESET;
            diff_threshold_reg <= FNIF_DIFF_THRESHOLD_RESET;
        end else begin
            image_width_reg    <= image_width_next;
            diff_threshold_reg <= diff_threshold_next;
        end
    end

    fnif_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .image_width (image_width_reg),
        .q_status    (q_status),
        .push        (q_push),
        .push_cmd    (q_push_cmd),
        .push_col    (q_push_col)
    );

    fnif_queue #(
        .COL_W (CNT_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .push_col (q_push_col),
        .pop      (q_pop),
        .head_cmd (q_head_cmd),
        .head_col (q_head_col),
        .status   (q_status)
    );

    fnif_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_cmd       (q_head_cmd),
        .head_col       (q_head_col),
        .q_status       (q_status),
        .pop            (q_pop),
        .diff_threshold (diff_threshold_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("classified item pushed into a full queue");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_frame_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_end) |-> m_data.row_end)
        else $error("frame end flagged on a pixel that does not end a row");

    a_pop_only_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("sequencer popped an empty queue");
`endif

endmodule
`default_nettype wire
